/* design/inverted_page_table_core_defines.svh */
// ----------------------------------------------------------------------------
// inverted_page_table_core_defines.svh
// Assertion macros used by the checking file of the inverted page table.
// ----------------------------------------------------------------------------
`ifndef INVERTED_PAGE_TABLE_CORE_DEFINES_SVH
`define INVERTED_PAGE_TABLE_CORE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define IPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet during reset
`define IPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/ipt_pkg.sv */
// ----------------------------------------------------------------------------
// ipt_pkg
// Types, sizes and helpers of the inverted page table.
// ----------------------------------------------------------------------------
package ipt_pkg;

	localparam int FRAMES     = 64;
	localparam int SLOT_BITS  = $clog2(FRAMES);
	localparam int FRAME_BITS = 6;
	localparam int PID_BITS   = 16;
	localparam int VPN_BITS   = 20;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	typedef logic [FRAMES-1:0] slot_vec_t;

	typedef struct packed {
		cmd_t                  cmd;
		logic [FRAME_BITS-1:0] frame_index;
		logic [PID_BITS-1:0]   process_id;
		logic [VPN_BITS-1:0]   page_number;
		logic                  dirty_in;
	} req_t;

	typedef struct packed {
		logic                  hit;
		logic [FRAME_BITS-1:0] hit_frame;
		logic                  table_full;
		logic [FRAME_BITS-1:0] first_free;
	} rsp_t;

	typedef struct packed {
		logic                 wr;
		logic                 lookup;
		logic [SLOT_BITS-1:0] slot;
		logic [PID_BITS-1:0]  pid;
		logic [VPN_BITS-1:0]  vpn;
		logic                 dirty;
	} op_t;

	function automatic logic [SLOT_BITS-1:0] lowest_set(slot_vec_t v);
		logic [SLOT_BITS-1:0] idx;
		idx = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = SLOT_BITS'(i);
			end
		end
		return idx;
	endfunction

endpackage

/* design/inverted_page_table_core.sv */
// ----------------------------------------------------------------------------
// inverted_page_table_core
// Inverted page table: insert entries per frame, look up process and page.
//
//   channel  | direction | beat
//   ---------+-----------+---------------------------------------------
//   req      | in        | cmd, frame_index, process_id, page_number, dirty_in
//   rsp      | out       | hit, hit_frame, table_full, first_free
//
// One beat per cycle sustained while rsp_ready is held high; a request passes a
// queue slot, a parallel compare of all frames and a priority encode into rsp.
// The two-entry queue keeps taking requests while a response stalls, until full.
// Reset clears all valid marks at once; no clearing pass.
// ----------------------------------------------------------------------------
module inverted_page_table_core import ipt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic op_valid;
	logic op_ready;
	op_t  op;

	ipt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.op        (op)
	);

	ipt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.op        (op),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

/* design/ipt_front.sv */
// ----------------------------------------------------------------------------
// ipt_front
// Accepts request beats, decodes them into table operations and queues them.
// ----------------------------------------------------------------------------
module ipt_front import ipt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic op_valid,
	input  logic op_ready,
	output op_t  op
);

	localparam logic [1:0] DEPTH = 2'd2;

	op_t        fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	op_t        op_in;
	logic       push;
	logic       pop;

	always_comb begin
		op_in.wr     = (req.cmd == CMD_INSERT) && (32'(req.frame_index) < FRAMES);
		op_in.lookup = (req.cmd == CMD_LOOKUP);
		op_in.slot   = SLOT_BITS'(req.frame_index);
		op_in.pid    = req.process_id;
		op_in.vpn    = req.page_number;
		op_in.dirty  = req.dirty_in;
	end

	assign req_ready = (count_q != DEPTH);
	assign op_valid  = (count_q != 2'd0);
	assign op        = fifo_q[rd_ptr_q];
	assign push      = req_valid && req_ready;
	assign pop       = op_valid && op_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= op_in;
		end
	end

endmodule

/* design/ipt_back.sv */
// ----------------------------------------------------------------------------
// ipt_back
// Holds the frame table, matches all entries in parallel, encodes the lowest
// match and lowest free frame, and holds the response beat.
// ----------------------------------------------------------------------------
module ipt_back import ipt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic op_valid,
	output logic op_ready,
	input  op_t  op,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	slot_vec_t           valid_q;
	logic [PID_BITS-1:0] pid_q   [FRAMES];
	logic [VPN_BITS-1:0] vpn_q   [FRAMES];
	logic                dirty_q [FRAMES];

	logic      busy_s2;
	slot_vec_t match_s2;
	slot_vec_t occ_s2;
	logic      rsp_valid_q;
	rsp_t      rsp_q;

	slot_vec_t match;
	slot_vec_t occ_next;
	rsp_t      rsp_d;
	logic      take;
	logic      s2_go;

	assign s2_go    = busy_s2 && (!rsp_valid_q || rsp_ready);
	assign op_ready = !busy_s2 || s2_go;
	assign take     = op_valid && op_ready;

	always_comb begin
		for (int f = 0; f < FRAMES; f++) begin
			match[f] = op.lookup && valid_q[f] && (pid_q[f] == op.pid) && (vpn_q[f] == op.vpn);
		end
		occ_next = valid_q | (op.wr ? (slot_vec_t'(1) << op.slot) : '0);
	end

	always_comb begin
		rsp_d.hit        = |match_s2;
		rsp_d.hit_frame  = FRAME_BITS'(lowest_set(match_s2));
		rsp_d.table_full = &occ_s2;
		rsp_d.first_free = FRAME_BITS'(lowest_set(~occ_s2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			busy_s2     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take && op.wr) begin
				valid_q[op.slot] <= 1'b1;
			end
			if (take) begin
				busy_s2 <= 1'b1;
			end else if (s2_go) begin
				busy_s2 <= 1'b0;
			end
			if (s2_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && op.wr) begin
			pid_q[op.slot]   <= op.pid;
			vpn_q[op.slot]   <= op.vpn;
			dirty_q[op.slot] <= op.dirty;
		end
		if (take) begin
			match_s2 <= match;
			occ_s2   <= occ_next;
		end
		if (s2_go) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* design/ipt_checker.sv */
// ----------------------------------------------------------------------------
// ipt_checker
// Port-level checks of the inverted page table, bound to the top level.
// ----------------------------------------------------------------------------
`include "inverted_page_table_core_defines.svh"

module ipt_checker import ipt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	logic [2:0] pending_q;
	logic       req_beat;
	logic       rsp_beat;

	assign req_beat = req_valid && req_ready;
	assign rsp_beat = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 3'd0;
		end else if (req_beat && !rsp_beat) begin
			pending_q <= pending_q + 3'd1;
		end else if (rsp_beat && !req_beat) begin
			pending_q <= pending_q - 3'd1;
		end
	end

	`IPT_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp beat dropped or changed while stalled")
	`IPT_ASSERT_NOW(a_rsp_has_req, clk, arst_n, rsp_valid, pending_q != 3'd0, "rsp beat without an outstanding request")
	`IPT_ASSERT_NOW(a_miss_frame, clk, arst_n, rsp_valid && !rsp.hit, rsp.hit_frame == '0, "miss reports a nonzero frame")
	`IPT_ASSERT_NOW(a_full_free, clk, arst_n, rsp_valid && rsp.table_full, rsp.first_free == '0, "full table reports a nonzero free frame")

endmodule

bind inverted_page_table_core ipt_checker u_ipt_checker (.*);
